### rtl/core/blscan_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blscan_pkg
// Shared types, codes and default sizes for the bencode level scanner.
// ----------------------------------------------------------------------------
package blscan_pkg;

   // Default sizes
   localparam int MAX_DEPTH_DEF = 16;
   localparam int LEN_BITS_DEF  = 20;
   localparam int POS_BITS_DEF  = 16;

   // Fixed field widths
   localparam int CLASS_W = 4;
   localparam int DEPTH_W = 5;
   localparam int POSN_W  = 16;
   localparam int STAT_W  = 3;
   localparam int KIND_W  = 2;
   localparam int LIMIT_W = 20;
   localparam int CSR_AW  = 2;
   localparam int CSR_DW  = 20;

   // Byte classes
   localparam logic [CLASS_W-1:0] CLS_LIST_OPEN = 4'd0;
   localparam logic [CLASS_W-1:0] CLS_DICT_OPEN = 4'd1;
   localparam logic [CLASS_W-1:0] CLS_END       = 4'd2;
   localparam logic [CLASS_W-1:0] CLS_INT_START = 4'd3;
   localparam logic [CLASS_W-1:0] CLS_INT_BODY  = 4'd4;
   localparam logic [CLASS_W-1:0] CLS_LEN_DIGIT = 4'd5;
   localparam logic [CLASS_W-1:0] CLS_COLON     = 4'd6;
   localparam logic [CLASS_W-1:0] CLS_PAYLOAD   = 4'd7;
   localparam logic [CLASS_W-1:0] CLS_BAD       = 4'd8;

   // Status codes
   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_BELOW     = 3'd1;
   localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd2;
   localparam logic [STAT_W-1:0] ST_MALFORMED = 3'd3;
   localparam logic [STAT_W-1:0] ST_LEN_OVER  = 3'd4;

   // Object kinds
   localparam logic [KIND_W-1:0] KIND_STRING = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INT    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LIST   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_DICT   = 2'd3;

   // Register indexes
   localparam logic [CSR_AW-1:0] REG_TARGET_KIND  = 2'd0;
   localparam logic [CSR_AW-1:0] REG_SKIP_FIRST   = 2'd1;
   localparam logic [CSR_AW-1:0] REG_LENGTH_LIMIT = 2'd2;

   // Register reset values
   localparam logic [KIND_W-1:0]  TARGET_KIND_RST  = KIND_LIST;
   localparam logic [LIMIT_W-1:0] LENGTH_LIMIT_RST = 20'hFFFFF;

   // Token characters
   localparam logic [7:0] CH_LIST  = 8'h6C; // 'l'
   localparam logic [7:0] CH_DICT  = 8'h64; // 'd'
   localparam logic [7:0] CH_END   = 8'h65; // 'e'
   localparam logic [7:0] CH_INT   = 8'h69; // 'i'
   localparam logic [7:0] CH_COLON = 8'h3A; // ':'
   localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
   localparam logic [7:0] CH_NINE  = 8'h39; // '9'

   // Scanner mode
   typedef enum logic [2:0] {
      MODE_EXPECT,
      MODE_LEN,
      MODE_PAYLOAD,
      MODE_INT,
      MODE_HALT
   } scan_mode_type;

endpackage : blscan_pkg
`default_nettype wire

### rtl/core/blscan_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blscan channel interfaces
// Valid/ready channels for input bytes, scan results and register writes.
// ----------------------------------------------------------------------------

// Input byte channel
interface blscan_req_if
   import blscan_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first;
   logic       last;

   modport source (output valid, data_byte, first, last, input ready);
   modport sink   (input valid, data_byte, first, last, output ready);
endinterface : blscan_req_if

// Result channel
interface blscan_rsp_if
   import blscan_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CLASS_W-1:0] byte_class;
   logic [DEPTH_W-1:0] depth;
   logic               hit;
   logic [POSN_W-1:0]  position;
   logic               not_found;
   logic [STAT_W-1:0]  status;

   modport source (output valid, byte_class, depth, hit, position, not_found, status,
                   input ready);
   modport sink   (input valid, byte_class, depth, hit, position, not_found, status,
                   output ready);
endinterface : blscan_rsp_if

// Register write channel
interface blscan_csr_if
   import blscan_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CSR_AW-1:0] addr;
   logic [CSR_DW-1:0] wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface : blscan_csr_if
`default_nettype wire

### rtl/core/bencode_level_scanner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bencode_level_scanner
// Byte-wide bencode scanner: classifies bytes, tracks nesting depth and flags
// the first object of the selected kind at the start level.
// ----------------------------------------------------------------------------
//  channel   dir   fields
//  req_if    in    data_byte, first, last
//  rsp_if    out   byte_class, depth, hit, position, not_found, status
//  csr_if    in    addr (0 target_kind, 1 skip_first, 2 length_limit), wdata
//
//  One byte per cycle while rsp_if.ready is high; input, then result register.
//  The input register feeds the scan logic, which updates the scan state and
//  loads the result register in the same cycle; the length step (x10 + digit
//  and limit compare) sets the critical path.
//  A full result register stalls the input register only when rsp_if.ready
//  is low. Synchronous reset clears the scan state and restores registers.
// ----------------------------------------------------------------------------
module bencode_level_scanner
   import blscan_pkg::*;
#(
   parameter int MAX_DEPTH = MAX_DEPTH_DEF,
   parameter int LEN_BITS  = LEN_BITS_DEF,
   parameter int POS_BITS  = POS_BITS_DEF
) (
   input  wire          clock,
   input  wire          reset,
   blscan_req_if.sink   req_if,
   blscan_rsp_if.source rsp_if,
   blscan_csr_if.sink   csr_if
);

   localparam int DB = $clog2(MAX_DEPTH + 1);
   localparam int CW = ((LEN_BITS > LIMIT_W) ? LEN_BITS : LIMIT_W) + 4;
   localparam logic [DB-1:0] DEPTH_MAX = DB'(MAX_DEPTH);
   localparam logic [CW-1:0] LEN_MASK  = CW'((64'd1 << LEN_BITS) - 64'd1);

   // Configuration registers
   logic [KIND_W-1:0]  target_kind_ff;
   logic               skip_first_ff;
   logic [LIMIT_W-1:0] length_limit_ff;

   // Input register
   logic       s_vld_ff;
   logic [7:0] s_byte_ff;
   logic       s_first_ff;
   logic       s_last_ff;

   // Scan state
   scan_mode_type       mode_ff, mode_in, mode_cur;
   logic [LEN_BITS-1:0] acc_ff, acc_in, acc_cur;
   logic [LEN_BITS-1:0] pl_ff, pl_in, pl_cur;
   logic [DB-1:0]       depth_ff, depth_in, depth_cur;
   logic [POS_BITS-1:0] pos_ff, pos_in, pos_cur;
   logic                found_ff, found_in, found_cur;
   logic                pending_ff, pending_in, pending_cur;
   logic                left_ff, left_in, left_cur;

   // Result register
   logic               o_vld_ff;
   logic [CLASS_W-1:0] o_cls_ff, o_cls_in;
   logic [DEPTH_W-1:0] o_depth_ff, o_depth_in;
   logic               o_hit_ff, o_hit_in;
   logic [POSN_W-1:0]  o_pos_ff, o_pos_in;
   logic               o_nf_ff, o_nf_in;
   logic [STAT_W-1:0]  o_stat_ff, o_stat_in;

   logic              adv;
   logic              req_xfer;
   logic              dec_char;
   logic [3:0]        dig;
   logic [CW-1:0]     len_val;
   logic [CW-1:0]     len_cap;
   logic              len_over;
   logic              hit_ok;
   logic              open_ok;
   logic [KIND_W-1:0] byte_kind;
   logic [DB+4:0]     depth_wide;
   logic [POS_BITS+POSN_W-1:0] pos_wide;
   logic [7:0]        dig_full;

   // Handshakes
   assign adv           = s_vld_ff && (!o_vld_ff || rsp_if.ready);
   assign req_if.ready  = !s_vld_ff || adv;
   assign req_xfer      = req_if.valid && req_if.ready;
   assign csr_if.ready  = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         target_kind_ff  <= TARGET_KIND_RST;
         skip_first_ff   <= 1'b0;
         length_limit_ff <= LENGTH_LIMIT_RST;
      end else if (csr_if.valid) begin
         unique case (csr_if.addr)
            REG_TARGET_KIND:  target_kind_ff  <= csr_if.wdata[KIND_W-1:0];
            REG_SKIP_FIRST:   skip_first_ff   <= csr_if.wdata[0];
            REG_LENGTH_LIMIT: length_limit_ff <= csr_if.wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff <= 1'b0;
      end else if (req_if.ready) begin
         s_vld_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s_byte_ff  <= req_if.data_byte;
         s_first_ff <= req_if.first;
         s_last_ff  <= req_if.last;
      end
   end

   // State as seen by this byte: a first byte restarts everything
   always_comb begin
      if (s_first_ff) begin
         mode_cur    = MODE_EXPECT;
         acc_cur     = '0;
         pl_cur      = '0;
         depth_cur   = '0;
         pos_cur     = '0;
         found_cur   = 1'b0;
         pending_cur = 1'b1;
         left_cur    = 1'b0;
      end else begin
         mode_cur    = mode_ff;
         acc_cur     = acc_ff;
         pl_cur      = pl_ff;
         depth_cur   = depth_ff;
         pos_cur     = pos_ff;
         found_cur   = found_ff;
         pending_cur = pending_ff;
         left_cur    = left_ff;
      end
   end

   // Byte decode and length arithmetic
   assign dec_char = (s_byte_ff >= CH_ZERO) && (s_byte_ff <= CH_NINE);
   assign dig_full = s_byte_ff - CH_ZERO;
   assign dig      = dig_full[3:0];
   assign len_val  = (mode_cur == MODE_LEN)
                   ? ((CW'(acc_cur) << 3) + (CW'(acc_cur) << 1) + CW'(dig))
                   : CW'(dig);
   assign len_cap  = (CW'(length_limit_ff) < LEN_MASK) ? CW'(length_limit_ff) : LEN_MASK;
   assign len_over = len_val > len_cap;

   // Hit qualification at the start level
   assign hit_ok  = (depth_cur == '0) && !found_cur && !left_cur
                 && !(skip_first_ff && pending_cur);
   assign open_ok = depth_cur < DEPTH_MAX;

   always_comb begin
      priority if (s_byte_ff == CH_LIST) begin
         byte_kind = KIND_LIST;
      end else if (s_byte_ff == CH_DICT) begin
         byte_kind = KIND_DICT;
      end else if (s_byte_ff == CH_INT) begin
         byte_kind = KIND_INT;
      end else begin
         byte_kind = KIND_STRING;
      end
   end

   // Next state
   always_comb begin
      mode_in    = mode_cur;
      acc_in     = acc_cur;
      pl_in      = pl_cur;
      depth_in   = depth_cur;
      left_in    = left_cur;
      pending_in = 1'b0;
      pos_in     = pos_cur + POS_BITS'(1);
      unique case (mode_cur)
         MODE_EXPECT: begin
            priority if (s_byte_ff == CH_LIST || s_byte_ff == CH_DICT) begin
               if (open_ok) begin
                  depth_in = depth_cur + DB'(1);
               end else begin
                  mode_in = MODE_HALT;
               end
            end else if (s_byte_ff == CH_END) begin
               if (depth_cur == '0) begin
                  left_in = 1'b1;
               end else begin
                  depth_in = depth_cur - DB'(1);
               end
            end else if (s_byte_ff == CH_INT) begin
               mode_in = MODE_INT;
            end else if (dec_char) begin
               acc_in  = LEN_BITS'(dig);
               mode_in = len_over ? MODE_HALT : MODE_LEN;
            end else begin
               mode_in = MODE_HALT;
            end
         end
         MODE_LEN: begin
            priority if (dec_char) begin
               if (len_over) begin
                  mode_in = MODE_HALT;
               end else begin
                  acc_in = len_val[LEN_BITS-1:0];
               end
            end else if (s_byte_ff == CH_COLON) begin
               pl_in   = acc_cur;
               acc_in  = '0;
               mode_in = (acc_cur != '0) ? MODE_PAYLOAD : MODE_EXPECT;
            end else begin
               mode_in = MODE_HALT;
            end
         end
         MODE_PAYLOAD: begin
            if (pl_cur != '0) begin
               pl_in = pl_cur - LEN_BITS'(1);
            end
            if (pl_in == '0) begin
               mode_in = MODE_EXPECT;
            end
         end
         MODE_INT: begin
            if (s_byte_ff == CH_END) begin
               mode_in = MODE_EXPECT;
            end
         end
         MODE_HALT: begin
            mode_in = MODE_HALT;
         end
         default: begin
            mode_in = MODE_HALT;
         end
      endcase
   end

   // Result fields
   always_comb begin
      o_cls_in  = CLS_BAD;
      o_stat_in = ST_OK;
      o_hit_in  = 1'b0;
      unique case (mode_cur)
         MODE_EXPECT: begin
            priority if (s_byte_ff == CH_LIST || s_byte_ff == CH_DICT) begin
               o_cls_in  = (s_byte_ff == CH_LIST) ? CLS_LIST_OPEN : CLS_DICT_OPEN;
               o_stat_in = open_ok ? ST_OK : ST_OVERFLOW;
               o_hit_in  = open_ok && hit_ok && (byte_kind == target_kind_ff);
            end else if (s_byte_ff == CH_END) begin
               o_cls_in  = CLS_END;
               o_stat_in = (depth_cur == '0) ? ST_BELOW : ST_OK;
            end else if (s_byte_ff == CH_INT) begin
               o_cls_in = CLS_INT_START;
               o_hit_in = hit_ok && (byte_kind == target_kind_ff);
            end else if (dec_char) begin
               o_cls_in  = CLS_LEN_DIGIT;
               o_stat_in = len_over ? ST_LEN_OVER : ST_OK;
               o_hit_in  = hit_ok && (target_kind_ff == KIND_STRING);
            end else begin
               o_stat_in = ST_MALFORMED;
            end
         end
         MODE_LEN: begin
            priority if (dec_char) begin
               o_cls_in  = CLS_LEN_DIGIT;
               o_stat_in = len_over ? ST_LEN_OVER : ST_OK;
            end else if (s_byte_ff == CH_COLON) begin
               o_cls_in = CLS_COLON;
            end else begin
               o_stat_in = ST_MALFORMED;
            end
         end
         MODE_PAYLOAD: begin
            o_cls_in = CLS_PAYLOAD;
         end
         MODE_INT: begin
            o_cls_in = (s_byte_ff == CH_END) ? CLS_END : CLS_INT_BODY;
         end
         MODE_HALT: begin
            o_stat_in = ST_MALFORMED;
         end
         default: begin
            o_stat_in = ST_MALFORMED;
         end
      endcase
   end

   assign found_in   = found_cur | o_hit_in;
   assign depth_wide = (DB + 5)'(depth_in);
   assign pos_wide   = (POS_BITS + POSN_W)'(pos_cur);
   assign o_depth_in = depth_wide[DEPTH_W-1:0];
   assign o_pos_in   = pos_wide[POSN_W-1:0];
   assign o_nf_in    = s_last_ff && !found_in;

   // Scan state update
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_EXPECT;
         acc_ff     <= '0;
         pl_ff      <= '0;
         depth_ff   <= '0;
         pos_ff     <= '0;
         found_ff   <= 1'b0;
         pending_ff <= 1'b1;
         left_ff    <= 1'b0;
      end else if (adv) begin
         mode_ff    <= mode_in;
         acc_ff     <= acc_in;
         pl_ff      <= pl_in;
         depth_ff   <= depth_in;
         pos_ff     <= pos_in;
         found_ff   <= found_in;
         pending_ff <= pending_in;
         left_ff    <= left_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (adv) begin
         o_vld_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         o_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_cls_ff   <= o_cls_in;
         o_depth_ff <= o_depth_in;
         o_hit_ff   <= o_hit_in;
         o_pos_ff   <= o_pos_in;
         o_nf_ff    <= o_nf_in;
         o_stat_ff  <= o_stat_in;
      end
   end

   assign rsp_if.valid      = o_vld_ff;
   assign rsp_if.byte_class = o_cls_ff;
   assign rsp_if.depth      = o_depth_ff;
   assign rsp_if.hit        = o_hit_ff;
   assign rsp_if.position   = o_pos_ff;
   assign rsp_if.not_found  = o_nf_ff;
   assign rsp_if.status     = o_stat_ff;

endmodule : bencode_level_scanner
`default_nettype wire

### test/blscan_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blscan_result_checker
// Watches the byte, result and register channels of the bencode level
// scanner, predicts one result per accepted byte and compares every result
// field by field with the oldest prediction still due.
// ----------------------------------------------------------------------------
module blscan_result_checker
   import blscan_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   blscan_req_if       req_ch,
   blscan_rsp_if       rsp_ch,
   blscan_csr_if       csr_ch,
   output int unsigned mismatches,
   output int unsigned outstanding
);

   typedef struct packed {
      logic [CLASS_W-1:0] byte_class;
      logic [DEPTH_W-1:0] depth;
      logic               hit;
      logic [POSN_W-1:0]  position;
      logic               not_found;
      logic [STAT_W-1:0]  status;
   } scan_result_type;

   // Register copies
   logic [KIND_W-1:0]  want_kind;
   logic               skip_lead;
   logic [LIMIT_W-1:0] len_limit;

   // Scan state
   scan_mode_type      mode;
   logic [LIMIT_W-1:0] len_acc;
   logic [LIMIT_W-1:0] pay_left;
   int unsigned        nest;
   logic [POSN_W-1:0]  byte_pos;
   logic               found;
   logic               lead_pending;
   logic               left_level;

   scan_result_type    due_results[$];

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic restart_scan();
      mode         = MODE_EXPECT;
      len_acc      = '0;
      pay_left     = '0;
      nest         = 0;
      byte_pos     = '0;
      found        = 1'b0;
      lead_pending = 1'b1;
      left_level   = 1'b0;
   endtask

   // Only the first object of the wanted kind at the start level counts
   function automatic logic claim_hit(input logic [KIND_W-1:0] kind);
      if (kind != want_kind || nest != 0 || found || left_level) return 1'b0;
      if (skip_lead && lead_pending) return 1'b0;
      found = 1'b1;
      return 1'b1;
   endfunction

   task automatic scan_byte(input logic [7:0] c, input logic lead, input logic tail,
                            output scan_result_type r);
      logic [31:0] grown;
      logic [3:0]  dval;
      logic        dec_char;
      r            = '0;
      r.byte_class = CLS_BAD;
      r.status     = ST_OK;
      dec_char     = (c >= CH_ZERO) && (c <= CH_NINE);
      dval         = 4'(c - CH_ZERO);
      if (lead) restart_scan();
      r.position = byte_pos;

      case (mode)
         MODE_EXPECT: begin
            if (c == CH_LIST || c == CH_DICT) begin
               r.byte_class = (c == CH_LIST) ? CLS_LIST_OPEN : CLS_DICT_OPEN;
               if (nest >= MAX_DEPTH_DEF) begin
                  r.status = ST_OVERFLOW;
                  mode     = MODE_HALT;
               end else begin
                  r.hit = claim_hit((c == CH_LIST) ? KIND_LIST : KIND_DICT);
                  nest++;
               end
            end else if (c == CH_END) begin
               r.byte_class = CLS_END;
               // close at the start level: flagged, depth held at zero
               if (nest == 0) begin
                  r.status   = ST_BELOW;
                  left_level = 1'b1;
               end else begin
                  nest--;
               end
            end else if (c == CH_INT) begin
               r.byte_class = CLS_INT_START;
               r.hit        = claim_hit(KIND_INT);
               mode         = MODE_INT;
            end else if (dec_char) begin
               r.byte_class = CLS_LEN_DIGIT;
               r.hit        = claim_hit(KIND_STRING);
               len_acc      = LIMIT_W'(dval);
               if (len_acc > len_limit) begin
                  r.status = ST_LEN_OVER;
                  mode     = MODE_HALT;
               end else begin
                  mode = MODE_LEN;
               end
            end else begin
               r.status = ST_MALFORMED;
               mode     = MODE_HALT;
            end
         end
         MODE_LEN: begin
            if (dec_char) begin
               r.byte_class = CLS_LEN_DIGIT;
               grown        = len_acc * 32'd10 + dval;
               if (grown > len_limit) begin
                  r.status = ST_LEN_OVER;
                  mode     = MODE_HALT;
               end else begin
                  len_acc = grown[LIMIT_W-1:0];
               end
            end else if (c == CH_COLON) begin
               r.byte_class = CLS_COLON;
               pay_left     = len_acc;
               len_acc      = '0;
               mode         = (pay_left != 0) ? MODE_PAYLOAD : MODE_EXPECT;
            end else begin
               r.status = ST_MALFORMED;
               mode     = MODE_HALT;
            end
         end
         MODE_PAYLOAD: begin
            r.byte_class = CLS_PAYLOAD;
            if (pay_left != 0) pay_left--;
            if (pay_left == 0) mode = MODE_EXPECT;
         end
         MODE_INT: begin
            if (c == CH_END) begin
               r.byte_class = CLS_END;
               mode         = MODE_EXPECT;
            end else begin
               r.byte_class = CLS_INT_BODY;
            end
         end
         // halted until the next buffer start
         default: begin
            r.byte_class = CLS_BAD;
            r.status     = ST_MALFORMED;
            mode         = MODE_HALT;
         end
      endcase

      lead_pending = 1'b0;
      byte_pos++;
      r.not_found  = tail && !found;
      r.depth      = nest[DEPTH_W-1:0];
   endtask

   // Transfer monitor
   always @(posedge clock) begin
      scan_result_type got;
      scan_result_type want;
      if (reset) begin
         want_kind = TARGET_KIND_RST;
         skip_lead = 1'b0;
         len_limit = LENGTH_LIMIT_RST;
         restart_scan();
         due_results.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.addr)
               REG_TARGET_KIND:  want_kind = csr_ch.wdata[KIND_W-1:0];
               REG_SKIP_FIRST:   skip_lead = csr_ch.wdata[0];
               REG_LENGTH_LIMIT: len_limit = csr_ch.wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end

         if (rsp_ch.valid && rsp_ch.ready) begin
            got.byte_class = rsp_ch.byte_class;
            got.depth      = rsp_ch.depth;
            got.hit        = rsp_ch.hit;
            got.position   = rsp_ch.position;
            got.not_found  = rsp_ch.not_found;
            got.status     = rsp_ch.status;
            if (due_results.size() == 0) begin
               report_mismatch($sformatf("result with nothing due, position %0d",
                                         got.position));
            end else begin
               want = due_results.pop_front();
               if (got.byte_class !== want.byte_class)
                  report_mismatch($sformatf("pos %0d byte_class %0d, want %0d",
                                            want.position, got.byte_class, want.byte_class));
               if (got.depth !== want.depth)
                  report_mismatch($sformatf("pos %0d depth %0d, want %0d",
                                            want.position, got.depth, want.depth));
               if (got.hit !== want.hit)
                  report_mismatch($sformatf("pos %0d hit %0b, want %0b",
                                            want.position, got.hit, want.hit));
               if (got.position !== want.position)
                  report_mismatch($sformatf("position %0d, want %0d",
                                            got.position, want.position));
               if (got.not_found !== want.not_found)
                  report_mismatch($sformatf("pos %0d not_found %0b, want %0b",
                                            want.position, got.not_found, want.not_found));
               if (got.status !== want.status)
                  report_mismatch($sformatf("pos %0d status %0d, want %0d",
                                            want.position, got.status, want.status));
            end
         end

         if (req_ch.valid && req_ch.ready) begin
            scan_byte(req_ch.data_byte, req_ch.first, req_ch.last, want);
            due_results.push_back(want);
         end
      end
      outstanding <= due_results.size();
   end

endmodule : blscan_result_checker

### test/bencode_level_scanner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bencode_level_scanner_tb
// Feeds the scanner directed buffers, then random bencoded buffers (mostly
// well formed, some truncated, corrupted or noisy) under several register
// settings and idle patterns; the result checker does the comparing.
// ----------------------------------------------------------------------------
module bencode_level_scanner_tb;
   import blscan_pkg::*;

   logic clock;
   logic reset;

   blscan_req_if req_ch ();
   blscan_rsp_if rsp_ch ();
   blscan_csr_if csr_ch ();

   int unsigned mismatches;
   int unsigned outstanding;

   int          snd_idle;
   int          rcv_idle;
   int          hold_left;
   int          bytes_sent;
   int          end_at;
   logic [7:0]  frame[$];

   bencode_level_scanner DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   blscan_result_checker u_result_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_ch      (csr_ch),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Result side: random stalls, or a long hold-off when asked for
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rcv_idle);
         end
      end
   end

   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // One byte transfer, with random gaps ahead of it
   task automatic push_byte(input logic [7:0] b, input logic lead, input logic tail);
      while ($urandom_range(99) < snd_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.first     <= lead;
      req_ch.last      <= tail;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame();
      if (end_at < 0) end_at = frame.size() - 1;
      foreach (frame[k]) push_byte(frame[k], k == 0, k == end_at);
      frame.delete();
      end_at = -1;
   endtask

   // Stop offering and wait for every predicted result
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_AW-1:0] idx, input logic [CSR_DW-1:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.addr  <= idx;
      csr_ch.wdata <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   // Unused upper bits of the narrow registers get random values
   task automatic set_config(input logic [KIND_W-1:0] kind, input logic skip,
                             input logic [LIMIT_W-1:0] limit);
      write_reg(REG_TARGET_KIND, {18'($urandom_range(20'h3FFFF)), kind});
      write_reg(REG_SKIP_FIRST, {19'($urandom_range(20'h7FFFF)), skip});
      write_reg(REG_LENGTH_LIMIT, limit);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic push_text(input string s);
      for (int k = 0; k < s.len(); k++) frame.push_back(s[k]);
   endtask

   function automatic logic [7:0] any_token();
      case ($urandom_range(6))
         0: return CH_LIST;
         1: return CH_DICT;
         2: return CH_END;
         3: return CH_INT;
         4: return CH_COLON;
         5: return CH_ZERO + 8'($urandom_range(9));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic add_string(input int len);
      if ($urandom_range(9) == 0) frame.push_back(CH_ZERO);
      push_text($sformatf("%0d", len));
      frame.push_back(CH_COLON);
      repeat (len) frame.push_back(8'($urandom_range(255)));
   endtask

   // Integer body may hold any byte but the end token
   task automatic add_int();
      logic [7:0] b;
      frame.push_back(CH_INT);
      repeat ($urandom_range(4)) begin
         do b = 8'($urandom_range(255)); while (b == CH_END);
         frame.push_back(b);
      end
      frame.push_back(CH_END);
   endtask

   task automatic add_scalar();
      int pick;
      pick = $urandom_range(99);
      if (pick < 50) add_int();
      else if (pick < 85) add_string($urandom_range(4));
      else if (pick < 97) add_string($urandom_range(5, 12));
      else add_string($urandom_range(13, 40));
   endtask

   // One complete object, containers nested up to max_nest
   task automatic add_object(input int max_nest);
      int lvl;
      int pick;
      int steps;
      lvl   = 0;
      steps = 0;
      do begin
         pick = $urandom_range(99);
         if (lvl > 0 && pick < 30) begin
            frame.push_back(CH_END);
            lvl--;
         end else if (pick < 55 && lvl < max_nest) begin
            frame.push_back($urandom_range(1) ? CH_LIST : CH_DICT);
            lvl++;
         end else begin
            add_scalar();
         end
         steps++;
      end while (lvl > 0 && steps < 24);
      repeat (lvl) frame.push_back(CH_END);
   endtask

   task automatic build_frame(input int nth);
      int v;
      int cut;
      v = $urandom_range(99);
      if (nth % 20 == 5) v = 100;
      else if (nth % 20 == 15) v = 101;

      if (v < 62) begin
         repeat ($urandom_range(1, 3)) add_object($urandom_range(5));
      end else if (v < 70) begin
         // cut short: next buffer starts mid-object
         repeat ($urandom_range(1, 2)) add_object($urandom_range(4));
         cut = $urandom_range(1, frame.size());
         while (frame.size() > cut) void'(frame.pop_back());
      end else if (v < 78) begin
         repeat ($urandom_range(1, 2)) add_object($urandom_range(4));
         frame[$urandom_range(frame.size() - 1)] = 8'($urandom_range(255));
      end else if (v < 84) begin
         // stray close at the start level
         if ($urandom_range(1)) add_object(3);
         frame.push_back(CH_END);
         repeat ($urandom_range(1, 2)) add_object(3);
      end else if (v < 90) begin
         repeat ($urandom_range(1, 10)) frame.push_back(any_token());
      end else if (v < 95) begin
         // bytes past the last flag, same buffer
         add_object(4);
         end_at = frame.size() - 1;
         repeat ($urandom_range(1, 4)) frame.push_back(any_token());
      end else if (v < 100) begin
         if ($urandom_range(1)) push_text($sformatf("%0d", $urandom_range(20'hFFFFF)));
         else push_text($sformatf("%07d", $urandom_range(9999999)));
         frame.push_back(CH_COLON);
         repeat (3) frame.push_back(8'($urandom_range(255)));
      end else if (v == 100) begin
         // nesting past the depth limit
         repeat ($urandom_range(16, 18)) frame.push_back($urandom_range(1) ? CH_LIST : CH_DICT);
         frame.push_back(any_token());
         frame.push_back(CH_END);
      end else begin
         push_text(((nth / 20) % 2 == 1) ? "1048575" : "1048576");
         frame.push_back(CH_COLON);
         repeat (2) frame.push_back(8'($urandom_range(255)));
      end
   endtask

   // Stimulus and verdict
   initial begin
      logic [LIMIT_W-1:0] limit;
      int                 nth;
      int                 seg_start;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= '0;
      req_ch.first     <= 1'b0;
      req_ch.last      <= 1'b0;
      csr_ch.valid     <= 1'b0;
      csr_ch.addr      <= '0;
      csr_ch.wdata     <= '0;
      snd_idle   = 14;
      rcv_idle   = 80;
      hold_left  = 0;
      bytes_sent = 0;
      end_at     = -1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: integer skipped, list hit at the start level
      push_text("i-ele");
      send_frame();
      // stray close, zero length, bad byte on the last flag, halted byte after it
      push_text("ele0:");
      frame.push_back(8'h00);
      frame.push_back(8'hFF);
      end_at = 5;
      send_frame();
      // dictionary sought, leading object skipped, length over a limit of 2
      drain();
      set_config(KIND_DICT, 1'b1, 20'd2);
      push_text("dede3");
      send_frame();
      // string sought with a leading zero, payload extremes, bad length byte
      drain();
      set_config(KIND_STRING, 1'b0, 20'd2);
      push_text("02:");
      frame.push_back(8'hFF);
      frame.push_back(8'h00);
      push_text("1x");
      send_frame();

      // Random buffers, register settings changed between segments
      nth = 0;
      for (int seg = 0; seg < 15; seg++) begin
         drain();
         case (seg / 5)
            0: begin snd_idle = 14; rcv_idle = 80; end
            1: begin snd_idle = 80; rcv_idle = 14; end
            default: begin snd_idle = 0; rcv_idle = 0; end
         endcase
         case (seg % 5)
            0: limit = '0;
            1: limit = LENGTH_LIMIT_RST;
            2: limit = LIMIT_W'($urandom_range(1, 20));
            3: limit = LIMIT_W'($urandom_range(20'hFFFFF));
            default: limit = 20'd9;
         endcase
         set_config(KIND_W'(seg % 4), 1'((seg / 4) % 2), limit);
         // long result hold-off while bytes keep coming
         if (seg == 12) hold_left = 90;
         seg_start = bytes_sent;
         while (bytes_sent - seg_start < 34) begin
            build_frame(nth);
            nth++;
            send_frame();
         end
      end

      // Leading string skipped, then an integer and a list at the start level
      drain();
      set_config(KIND_LIST, 1'b1, LENGTH_LIMIT_RST);
      add_string(4);
      push_text("i7el");
      send_frame();

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule : bencode_level_scanner_tb
